// File: rtl/core/tkc_pkg.sv
`timescale 1ns / 1ps

package tkc_pkg;

    localparam int KEY_W    = 64;
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Widest live count the saturation logic handles (ENTRIES up to 127).
    localparam int LIVE_EXT_W = 7;

    localparam logic [TIME_W-1:0]  TTL_RESET       = 32'd60000;
    localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 8'd64;
    localparam logic [LIVE_W-1:0]  LIVE_MAX        = 4'd15;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_TAKE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_TV      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHANNEL = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_MISS   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_HIT    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STORED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 1'd1;

endpackage

// File: rtl/core/tkc_cell.sv
`timescale 1ns / 1ps

module tkc_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 3,
    parameter int CNT_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tkc_pkg::TIME_W-1:0] ttl_ms,
    input  logic [IDX_W+CNT_W+2*tkc_pkg::TIME_W+tkc_pkg::KEY_W
                  +tkc_pkg::HANDLE_W+tkc_pkg::COUNT_W+2*IDX_W+6-1:0] pkt_in,
    output logic [IDX_W+CNT_W+2*tkc_pkg::TIME_W+tkc_pkg::KEY_W
                  +tkc_pkg::HANDLE_W+tkc_pkg::COUNT_W+2*IDX_W+6-1:0] pkt_out,
    input  logic [2*IDX_W-IDX_W+tkc_pkg::KEY_W+tkc_pkg::HANDLE_W
                  +tkc_pkg::COUNT_W+tkc_pkg::TIME_W+3-1:0]           cmt_in
);
    import tkc_pkg::*;

    typedef struct packed {
        logic                vld;
        logic                store;
        logic                look;
        logic [KEY_W-1:0]    key;
        logic                kind;
        logic [TIME_W-1:0]   now;
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic [HANDLE_W-1:0] hit_handle;
        logic [COUNT_W-1:0]  hit_count;
        logic                free;
        logic [IDX_W-1:0]    free_idx;
        logic [IDX_W-1:0]    old_idx;
        logic [TIME_W-1:0]   old_stamp;
        logic [CNT_W-1:0]    live;
    } pkt_t;

    typedef struct packed {
        logic                wr_en;
        logic                clr_en;
        logic [IDX_W-1:0]    slot;
        logic [KEY_W-1:0]    key;
        logic                kind;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   stamp;
    } cmt_t;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    pkt_t pin;
    pkt_t pkt_reg;
    pkt_t pkt_next;
    pkt_t pout;
    cmt_t cmt;

    logic                vld_reg;
    logic                valid_reg;
    logic                valid_next;
    logic [KEY_W-1:0]    key_reg;
    logic                kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [TIME_W-1:0]   stamp_reg;

    logic [TIME_W-1:0]   age;
    logic [TIME_W-1:0]   stamp_diff;
    logic                expired;
    logic                alive;
    logic                match;
    logic                sel_me;

    assign pin     = pkt_t'(pkt_in);
    assign cmt     = cmt_t'(cmt_in);
    assign pkt_out = pout;

    always_comb
    begin
        pout     = pkt_reg;
        pout.vld = vld_reg;
    end

    assign age        = pin.now - stamp_reg;
    assign stamp_diff = stamp_reg - pin.old_stamp;
    assign expired    = pin.vld && valid_reg && (age > ttl_ms);
    assign alive      = valid_reg && !expired;
    assign match      = alive && pin.look && (key_reg == pin.key) && (kind_reg == pin.kind);
    assign sel_me     = (cmt.slot == MY_IDX);

    always_comb
    begin
        pkt_next = pin;
        if (pin.vld)
        begin
            // later matches win, as the lookup keeps the last hit
            if (match)
            begin
                pkt_next.hit        = 1'b1;
                pkt_next.hit_idx    = MY_IDX;
                pkt_next.hit_handle = handle_reg;
                pkt_next.hit_count  = count_reg;
            end
            if (!alive && !pin.free)
            begin
                pkt_next.free     = 1'b1;
                pkt_next.free_idx = MY_IDX;
            end
            // strictly older by wrapping difference; ties keep the lower slot
            if (INDEX == 0 || stamp_diff[TIME_W-1])
            begin
                pkt_next.old_idx   = MY_IDX;
                pkt_next.old_stamp = stamp_reg;
            end
            if (alive)
            begin
                pkt_next.live = pin.live + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmt.wr_en && sel_me)
        begin
            valid_next = 1'b1;
        end
        else if (cmt.clr_en && sel_me)
        begin
            valid_next = 1'b0;
        end
        else if (expired)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            vld_reg   <= pkt_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg.vld        <= 1'b0;
        pkt_reg.store      <= pkt_next.store;
        pkt_reg.look       <= pkt_next.look;
        pkt_reg.key        <= pkt_next.key;
        pkt_reg.kind       <= pkt_next.kind;
        pkt_reg.now        <= pkt_next.now;
        pkt_reg.hit        <= pkt_next.hit;
        pkt_reg.hit_idx    <= pkt_next.hit_idx;
        pkt_reg.hit_handle <= pkt_next.hit_handle;
        pkt_reg.hit_count  <= pkt_next.hit_count;
        pkt_reg.free       <= pkt_next.free;
        pkt_reg.free_idx   <= pkt_next.free_idx;
        pkt_reg.old_idx    <= pkt_next.old_idx;
        pkt_reg.old_stamp  <= pkt_next.old_stamp;
        pkt_reg.live       <= pkt_next.live;
        if (cmt.wr_en && sel_me)
        begin
            key_reg    <= cmt.key;
            kind_reg   <= cmt.kind;
            handle_reg <= cmt.handle;
            count_reg  <= cmt.count;
            stamp_reg  <= cmt.stamp;
        end
    end

endmodule

// File: rtl/core/ttl_keyed_cache_consume_on_hit_core.sv
`timescale 1ns / 1ps
// A request is registered at the head, walks the cell chain one cell per cycle,
// is captured in the tail register and commits once the result register is free;
// a new request is accepted only after that commit (in_ready is low until then).
// Reset (async, active low): all entries invalid, ttl_ms = 60000, max_count = 64,
// no result pending. Config writes are accepted every cycle.
module ttl_keyed_cache_consume_on_hit_core #(
    parameter int ENTRIES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [tkc_pkg::KEY_W-1:0]       key,
    input  logic [tkc_pkg::KIND_W-1:0]      kind,
    input  logic [tkc_pkg::HANDLE_W-1:0]    handle,
    input  logic [tkc_pkg::COUNT_W-1:0]     count,
    input  logic [tkc_pkg::TIME_W-1:0]      now_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tkc_pkg::STATUS_W-1:0]    status,
    output logic [tkc_pkg::HANDLE_W-1:0]    out_handle,
    output logic [tkc_pkg::COUNT_W-1:0]     out_count,
    output logic [tkc_pkg::LIVE_W-1:0]      live_entries,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tkc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tkc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic                vld;
        logic                store;
        logic                look;
        logic [KEY_W-1:0]    key;
        logic                kind;
        logic [TIME_W-1:0]   now;
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic [HANDLE_W-1:0] hit_handle;
        logic [COUNT_W-1:0]  hit_count;
        logic                free;
        logic [IDX_W-1:0]    free_idx;
        logic [IDX_W-1:0]    old_idx;
        logic [TIME_W-1:0]   old_stamp;
        logic [CNT_W-1:0]    live;
    } pkt_t;

    typedef struct packed {
        logic                wr_en;
        logic                clr_en;
        logic [IDX_W-1:0]    slot;
        logic [KEY_W-1:0]    key;
        logic                kind;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   stamp;
    } cmt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;

    logic [TIME_W-1:0]  ttl_reg;
    logic [COUNT_W-1:0] max_count_reg;

    logic               head_vld_reg;
    pkt_t               head_reg;
    pkt_t               head_pkt;
    pkt_t               chain [0:ENTRIES-1];
    pkt_t               tail_reg;
    logic               rej_reg;
    logic [HANDLE_W-1:0] req_handle_reg;
    logic [COUNT_W-1:0] req_count_reg;

    logic               out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [LIVE_W-1:0]  live_reg;

    logic               accept;
    logic               reject;
    logic               commit_fire;
    cmt_t               cmt;
    logic [STATUS_W-1:0] res_status;
    logic [HANDLE_W-1:0] res_handle;
    logic [COUNT_W-1:0] res_count;
    logic [CNT_W-1:0]   res_live;
    logic [LIVE_EXT_W-1:0] live_ext;
    logic [LIVE_W-1:0]  live_sat;

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_handle   = out_handle_reg;
    assign out_count    = out_count_reg;
    assign live_entries = live_reg;

    assign reject = (key == '0) || (kind > KIND_CHANNEL) || (count == '0)
                    || (count > max_count_reg);

    always_comb
    begin
        head_pkt     = head_reg;
        head_pkt.vld = head_vld_reg;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            tkc_cell #(
                .INDEX (i),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ttl_ms  (ttl_reg),
                .pkt_in  (head_pkt),
                .pkt_out (chain[i]),
                .cmt_in  (cmt)
            );
        end
        else
        begin : g_next
            tkc_cell #(
                .INDEX (i),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ttl_ms  (ttl_reg),
                .pkt_in  (chain[i-1]),
                .pkt_out (chain[i]),
                .cmt_in  (cmt)
            );
        end
    end

    assign commit_fire = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmt.wr_en  = 1'b0;
        cmt.clr_en = 1'b0;
        cmt.slot   = tail_reg.old_idx;
        cmt.key    = tail_reg.key;
        cmt.kind   = tail_reg.kind;
        cmt.handle = req_handle_reg;
        cmt.count  = req_count_reg;
        cmt.stamp  = tail_reg.now;
        res_status = STAT_MISS;
        res_handle = '0;
        res_count  = '0;
        res_live   = tail_reg.live;
        if (tail_reg.store)
        begin
            if (rej_reg)
            begin
                res_status = STAT_REJECT;
            end
            else
            begin
                res_status = STAT_STORED;
                cmt.wr_en  = commit_fire;
                if (tail_reg.hit)
                begin
                    cmt.slot = tail_reg.hit_idx;
                end
                else if (tail_reg.free)
                begin
                    cmt.slot = tail_reg.free_idx;
                    res_live = tail_reg.live + CNT_W'(1);
                end
            end
        end
        else if (tail_reg.hit)
        begin
            res_status = STAT_HIT;
            res_handle = tail_reg.hit_handle;
            res_count  = tail_reg.hit_count;
            cmt.slot   = tail_reg.hit_idx;
            cmt.clr_en = commit_fire;
            res_live   = tail_reg.live - CNT_W'(1);
        end
    end

    assign live_ext = LIVE_EXT_W'(res_live);
    assign live_sat = (live_ext > LIVE_EXT_W'(LIVE_MAX)) ? LIVE_MAX : live_ext[LIVE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg       <= TTL_RESET;
            max_count_reg <= MAX_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TTL_MS:    ttl_reg       <= cfg_data;
                CFG_MAX_COUNT: max_count_reg <= cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        head_vld_reg <= 1'b1;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (chain[ENTRIES-1].vld)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (commit_fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (commit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg.vld        <= 1'b0;
            head_reg.store      <= (opcode == OP_STORE);
            head_reg.look       <= (key != '0) && (kind <= KIND_CHANNEL);
            head_reg.key        <= key;
            head_reg.kind       <= kind[0];
            head_reg.now        <= now_ms;
            head_reg.hit        <= 1'b0;
            head_reg.hit_idx    <= '0;
            head_reg.hit_handle <= '0;
            head_reg.hit_count  <= '0;
            head_reg.free       <= 1'b0;
            head_reg.free_idx   <= '0;
            head_reg.old_idx    <= '0;
            head_reg.old_stamp  <= '0;
            head_reg.live       <= '0;
            rej_reg             <= reject;
            req_handle_reg      <= handle;
            req_count_reg       <= count;
        end
        if (chain[ENTRIES-1].vld)
        begin
            tail_reg <= chain[ENTRIES-1];
        end
        if (commit_fire)
        begin
            status_reg     <= res_status;
            out_handle_reg <= res_handle;
            out_count_reg  <= res_count;
            live_reg       <= live_sat;
        end
    end

endmodule

// File: rtl/core/tkc_checker.sv
`timescale 1ns / 1ps

module tkc_checker #(
    parameter int ENTRIES = 8
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tkc_pkg::STATUS_W-1:0] status,
    input logic [tkc_pkg::HANDLE_W-1:0] out_handle,
    input logic [tkc_pkg::COUNT_W-1:0]  out_count,
    input logic [tkc_pkg::LIVE_W-1:0]   live_entries
);
    import tkc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(out_handle) && $stable(out_count) && $stable(live_entries))
        else $error("result changed while stalled");

    // one request in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_HIT |-> out_handle == '0 && out_count == '0)
        else $error("payload on a non-hit result");

    // stores never keep a zero count
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_HIT |-> out_count != '0)
        else $error("hit with zero count");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ENTRIES > 15) || (int'(live_entries) <= ENTRIES))
        else $error("live count above capacity");

endmodule

bind ttl_keyed_cache_consume_on_hit_core tkc_checker #(
    .ENTRIES (ENTRIES)
) u_tkc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_handle   (out_handle),
    .out_count    (out_count),
    .live_entries (live_entries)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import tkc_pkg::*;

    localparam int N_SLOTS     = 8;
    localparam int KEY_POOL    = 6;
    localparam int STALL_LIMIT = 2000;

    localparam logic [KIND_W-1:0] KIND_OTHER     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER_MAX = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_ALL_ONES   = '1;

    typedef struct packed {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   now;
    } cache_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic [LIVE_W-1:0]   live;
    } cache_rsp_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  opcode = OP_STORE;
    logic [KEY_W-1:0]      key = '0;
    logic [KIND_W-1:0]     kind = KIND_TV;
    logic [HANDLE_W-1:0]   handle = '0;
    logic [COUNT_W-1:0]    count = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   out_handle;
    logic [COUNT_W-1:0]    out_count;
    logic [LIVE_W-1:0]     live_entries;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TTL_MS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // cache image tracked by the testbench scoreboard
    logic                slot_valid [N_SLOTS];
    logic [KEY_W-1:0]    slot_key [N_SLOTS];
    logic                slot_kind [N_SLOTS];
    logic [HANDLE_W-1:0] slot_handle [N_SLOTS];
    logic [COUNT_W-1:0]  slot_count [N_SLOTS];
    logic [TIME_W-1:0]   slot_stamp [N_SLOTS];
    logic [TIME_W-1:0]   cur_ttl = TTL_RESET;
    logic [COUNT_W-1:0]  cur_max_count = MAX_COUNT_RESET;

    cache_rsp_t expected_replies [$];
    cache_req_t accepted_req;
    cache_rsp_t expected_rsp;

    int requests_sent = 0;
    int replies_checked = 0;
    int failures = 0;
    int idle_cycles = 0;
    int settings_used = 1;
    int status_tally [4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int ready_run = 0;
    int stall_run = 0;

    logic [TIME_W-1:0]  phase_ttl = TTL_RESET;
    logic [COUNT_W-1:0] phase_max = MAX_COUNT_RESET;
    logic [TIME_W-1:0]  clock_ms = '0;
    logic [KEY_W-1:0]   key_pool [KEY_POOL];

    ttl_keyed_cache_consume_on_hit_core #(
        .ENTRIES (N_SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .key          (key),
        .kind         (kind),
        .handle       (handle),
        .count        (count),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_handle   (out_handle),
        .out_count    (out_count),
        .live_entries (live_entries),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < N_SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
        end
    end

    // Sweep, then store or take; updates the cache image and returns the reply.
    function automatic cache_rsp_t predict_cache_op(input cache_req_t r);
        cache_rsp_t        res;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] diff;
        int                slot;
        int                n;
        int                i;
        res = '0;
        for (i = 0; i < N_SLOTS; i++)
        begin
            age = r.now - slot_stamp[i];
            if (slot_valid[i] && age > cur_ttl)
                slot_valid[i] = 1'b0;
        end
        slot = -1;
        for (i = 0; i < N_SLOTS; i++)
        begin
            if (slot_valid[i] && slot_key[i] == r.key && r.kind <= KIND_CHANNEL
                    && slot_kind[i] == r.kind[0])
                slot = i;
        end
        if (r.op == OP_STORE)
        begin
            if (r.key == '0 || r.kind > KIND_CHANNEL || r.count == '0
                    || r.count > cur_max_count)
            begin
                res.status = STAT_REJECT;
            end
            else
            begin
                if (slot < 0)
                begin
                    for (i = N_SLOTS - 1; i >= 0; i--)
                    begin
                        if (!slot_valid[i])
                            slot = i;
                    end
                end
                if (slot < 0)
                begin
                    // full: evict the oldest stamp, wrap-aware, lowest index on ties
                    slot = 0;
                    for (i = 1; i < N_SLOTS; i++)
                    begin
                        diff = slot_stamp[i] - slot_stamp[slot];
                        if (diff[TIME_W-1])
                            slot = i;
                    end
                end
                slot_valid[slot]  = 1'b1;
                slot_key[slot]    = r.key;
                slot_kind[slot]   = r.kind[0];
                slot_handle[slot] = r.handle;
                slot_count[slot]  = r.count;
                slot_stamp[slot]  = r.now;
                res.status = STAT_STORED;
            end
        end
        else if (slot >= 0)
        begin
            res.handle = slot_handle[slot];
            res.count  = slot_count[slot];
            slot_valid[slot] = 1'b0;
            res.status = STAT_HIT;
        end
        else
        begin
            res.status = STAT_MISS;
        end
        n = 0;
        for (i = 0; i < N_SLOTS; i++)
        begin
            if (slot_valid[i])
                n++;
        end
        res.live = (n > LIVE_MAX) ? LIVE_MAX : n[LIVE_W-1:0];
        return res;
    endfunction

    // Predicts on each accepted request, checks each accepted reply, watches for hangs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TTL_MS)
                    cur_ttl = cfg_data;
                else if (cfg_index == CFG_MAX_COUNT)
                    cur_max_count = cfg_data[COUNT_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                accepted_req = {opcode, key, kind, handle, count, now_ms};
                expected_rsp = predict_cache_op(accepted_req);
                expected_replies.push_back(expected_rsp);
                status_tally[expected_rsp.status]++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply with no request pending: status %0d", status);
                    failures++;
                end
                else
                begin
                    expected_rsp = expected_replies.pop_front();
                    if (status !== expected_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", expected_rsp.status, status);
                        failures++;
                    end
                    if (out_handle !== expected_rsp.handle)
                    begin
                        $error("out_handle: expected %0h, got %0h",
                               expected_rsp.handle, out_handle);
                        failures++;
                    end
                    if (out_count !== expected_rsp.count)
                    begin
                        $error("out_count: expected %0d, got %0d",
                               expected_rsp.count, out_count);
                        failures++;
                    end
                    if (live_entries !== expected_rsp.live)
                    begin
                        $error("live_entries: expected %0d, got %0d",
                               expected_rsp.live, live_entries);
                        failures++;
                    end
                end
                replies_checked++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no handshake for %0d cycles", idle_cycles);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    // reply side: ready runs broken by stalls of random length, some runs without stalls
    always @(posedge clk)
    begin
        if (ready_run > 0)
        begin
            out_ready <= 1'b1;
            ready_run--;
        end
        else if (stall_run > 0)
        begin
            out_ready <= 1'b0;
            stall_run--;
        end
        else
        begin
            ready_run = $urandom_range(1, 40);
            stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            out_ready <= 1'b1;
        end
    end

    // Valid is left high after accept; the next call either reloads it or drops it.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                                input logic [KIND_W-1:0] kd, input logic [HANDLE_W-1:0] h,
                                input logic [COUNT_W-1:0] c, input logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        kind     <= kd;
        handle   <= h;
        count    <= c;
        now_ms   <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (replies_checked != requests_sent)
            @(posedge clk);
    endtask

    // both registers in one back-to-back burst, only with the cache idle
    task automatic write_config(input logic [TIME_W-1:0] ttl, input logic [COUNT_W-1:0] maxc);
        logic [CFG_DATA_W-1:0] word;
        wait_idle();
        word = $urandom;
        word[COUNT_W-1:0] = maxc;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TTL_MS;
        cfg_data  <= ttl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_MAX_COUNT;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        phase_ttl = ttl;
        phase_max = maxc;
        settings_used++;
    endtask

    task automatic run_traffic(input logic [TIME_W-1:0] ttl, input logic [COUNT_W-1:0] maxc,
                               input int n_items);
        logic [KEY_W-1:0]   k;
        logic [KIND_W-1:0]  kd;
        logic [COUNT_W-1:0] c;
        logic               op;
        int                 sel;
        write_config(ttl, maxc);
        for (int j = 0; j < KEY_POOL; j++)
        begin
            key_pool[j] = {$urandom, $urandom};
        end
        key_pool[0] = KEY_ALL_ONES;
        key_pool[1] = 64'd1;
        clock_ms = $urandom;
        repeat (n_items)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                k = '0;
            else if (sel == 1)
                k = {$urandom, $urandom};
            else
                k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            kd = ($urandom_range(0, 9) == 0) ? KIND_W'($urandom_range(2, 3))
                                              : KIND_W'($urandom_range(0, 1));
            op = ($urandom_range(0, 1) == 0) ? OP_STORE : OP_TAKE;
            case ($urandom_range(0, 9))
                0: c = '0;
                1: c = phase_max;
                2: c = phase_max + 8'd1;
                3: c = COUNT_W'($urandom_range(0, 255));
                default: c = (phase_max == '0) ? 8'd1 : COUNT_W'($urandom_range(1, phase_max));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: clock_ms = clock_ms;
                3, 4, 5, 6: clock_ms = clock_ms + $urandom_range(1, 2000);
                7: clock_ms = clock_ms + phase_ttl;
                8: clock_ms = clock_ms + phase_ttl + 32'd1;
                default: clock_ms = clock_ms + $urandom;
            endcase
            send_request(op, k, kd, $urandom, c, clock_ms);
        end
    endtask

    task automatic test_store_take_basics();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FF00;
        send_request(OP_TAKE, 64'd5, KIND_TV, '0, '0, t0);
        send_request(OP_STORE, 64'd1, KIND_TV, 32'd0, 8'd1, t0);
        send_request(OP_STORE, KEY_ALL_ONES, KIND_CHANNEL, '1, MAX_COUNT_RESET, t0);
        // rejected stores: over the limit, zero count, zero key, other kinds
        send_request(OP_STORE, 64'd2, KIND_TV, 32'd5, MAX_COUNT_RESET + 8'd1, t0);
        send_request(OP_STORE, 64'd2, KIND_TV, 32'd5, 8'd0, t0);
        send_request(OP_STORE, 64'd0, KIND_TV, 32'd5, 8'd5, t0);
        send_request(OP_STORE, 64'd2, KIND_OTHER, 32'd5, 8'd5, t0);
        send_request(OP_STORE, 64'd2, KIND_OTHER_MAX, 32'd5, 8'd5, t0);
        send_request(OP_TAKE, 64'd0, KIND_TV, '0, '0, t0);
        send_request(OP_TAKE, 64'd1, KIND_OTHER_MAX, '0, '0, t0);
        send_request(OP_TAKE, 64'd1, KIND_CHANNEL, '0, '0, t0);
        // time has wrapped past zero; entry still young
        send_request(OP_TAKE, 64'd1, KIND_TV, '1, '1, t0 + 32'h200);
        send_request(OP_TAKE, 64'd1, KIND_TV, '0, '0, t0 + 32'h200);
        send_request(OP_STORE, KEY_ALL_ONES, KIND_CHANNEL, 32'h1234_5678, 8'd7, t0 + 32'h300);
        send_request(OP_TAKE, KEY_ALL_ONES, KIND_CHANNEL, '0, '0, t0 + 32'h300);
    endtask

    task automatic test_expiry_boundary();
        logic [TIME_W-1:0] t1;
        t1 = 32'h7FFF_FFF0;
        send_request(OP_STORE, 64'd3, KIND_TV, 32'hA5A5_0003, 8'd3, t1);
        send_request(OP_TAKE, 64'd3, KIND_TV, '0, '0, t1 + TTL_RESET);
        send_request(OP_STORE, 64'd4, KIND_TV, 32'hA5A5_0004, 8'd4, t1 + TTL_RESET);
        send_request(OP_TAKE, 64'd4, KIND_TV, '0, '0, t1 + TTL_RESET + TTL_RESET + 32'd1);
    endtask

    task automatic test_eviction_order();
        logic [TIME_W-1:0] t2;
        t2 = 32'h0001_0000;
        // equal stamps: the ninth store must push out the lowest slot
        for (int j = 0; j <= N_SLOTS; j++)
        begin
            send_request(OP_STORE, 64'd16 + KEY_W'(j), KIND_TV, HANDLE_W'(j),
                         COUNT_W'(j + 1), t2);
        end
        send_request(OP_TAKE, 64'd16, KIND_TV, '0, '0, t2);
        send_request(OP_TAKE, 64'd16 + KEY_W'(N_SLOTS), KIND_TV, '0, '0, t2);
    endtask

    task automatic test_ttl_extremes();
        run_traffic(32'd0, 8'd255, 220);
        run_traffic('1, 8'd1, 220);
    endtask

    task automatic test_count_limits();
        run_traffic(TTL_RESET, 8'd0, 40);
        run_traffic(32'd3000, 8'd255, 220);
    endtask

    task automatic test_mixed_traffic();
        repeat (3)
        begin
            run_traffic($urandom_range(50, 200000), COUNT_W'($urandom_range(1, 255)), 220);
        end
        run_traffic(TTL_RESET, MAX_COUNT_RESET, 200);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_store_take_basics();
        test_expiry_boundary();
        test_eviction_order();
        test_ttl_extremes();
        test_count_limits();
        test_mixed_traffic();
        wait_idle();
        repeat (N_SLOTS + 4) @(posedge clk);
        if (expected_replies.size() != 0)
        begin
            $error("%0d replies never arrived", expected_replies.size());
            failures++;
        end
        $display("Ran %0d requests over %0d ttl/max_count settings, wrapped time included.",
                 requests_sent, settings_used);
        $display("Replies: %0d hits, %0d misses, %0d stored, %0d rejected; %0d field errors.",
                 status_tally[STAT_HIT], status_tally[STAT_MISS],
                 status_tally[STAT_STORED], status_tally[STAT_REJECT], failures);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
